// ===== rtl/spd_pkg.sv =====
// Shared constants and types for the shortest path core.
// Used by the channel interfaces, the front end, the search engine and the top level.
package spd_pkg;

  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned CostBitsDef = 16;
  localparam int unsigned NodeW       = 6;
  localparam int unsigned CostInW     = 16;
  localparam int unsigned NumNodesW   = 7;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  localparam logic OpEdge  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [ApbAddrW-1:0] RegNumNodes = '0;

  // One classified command from the front end. For an edge node_a is the lower
  // endpoint and node_b the higher; for a query they are the start and end nodes.
  typedef struct packed {
    logic               is_query;
    logic [NodeW-1:0]   node_a;
    logic [NodeW-1:0]   node_b;
    logic [CostInW-1:0] cost;
  } spd_cmd_t;

endpackage

// ===== rtl/spd_stream_if.sv =====
// Valid/ready channel interfaces for command items and path results.
// Depends on spd_pkg for the field widths.
interface spd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [spd_pkg::NodeW-1:0]   edge_from;
  logic [spd_pkg::NodeW-1:0]   edge_to;
  logic [spd_pkg::CostInW-1:0] edge_cost;
  logic [spd_pkg::NodeW-1:0]   path_start;
  logic [spd_pkg::NodeW-1:0]   path_end;

  modport source (output valid, opcode, edge_from, edge_to, edge_cost, path_start, path_end,
                  input ready);
  modport sink (input valid, opcode, edge_from, edge_to, edge_cost, path_start, path_end,
                output ready);
endinterface

interface spd_out_if;
  logic                      valid;
  logic                      ready;
  logic [spd_pkg::NodeW-1:0] path_node;
  logic                      last;

  modport source (output valid, path_node, last, input ready);
  modport sink (input valid, path_node, last, output ready);
endinterface

// ===== rtl/spd_front.sv =====
// Front end: takes command items, drops out-of-range edges, orders edge endpoints
// and holds classified commands in a short queue. Depends on spd_pkg, spd_in_if.
module spd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  spd_in_if.sink                            item_i,
  input  logic [spd_pkg::NumNodesW-1:0]     num_nodes_i,
  input  logic                              clear_busy_i,
  output logic                              cmd_valid_o,
  output spd_pkg::spd_cmd_t                 cmd_o,
  input  logic                              cmd_ready_i
);

  localparam int unsigned Depth = spd_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned N7    = spd_pkg::NumNodesW;

  spd_pkg::spd_cmd_t q_mem [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              accept, push, pop, edge_ok;
  spd_pkg::spd_cmd_t entry;

  assign item_i.ready = (cnt_q != CntW'(Depth)) && !clear_busy_i;
  assign accept       = item_i.valid && item_i.ready;
  assign edge_ok      = (N7'(item_i.edge_from) < num_nodes_i) &&
                        (N7'(item_i.edge_to) < num_nodes_i);
  assign push         = accept && ((item_i.opcode == spd_pkg::OpQuery) || edge_ok);
  assign cmd_valid_o  = (cnt_q != '0);
  assign cmd_o        = q_mem[rd_ptr_q];
  assign pop          = cmd_valid_o && cmd_ready_i;

  always_comb begin
    entry.is_query = (item_i.opcode == spd_pkg::OpQuery);
    entry.cost     = item_i.edge_cost;
    if (entry.is_query) begin
      entry.node_a = item_i.path_start;
      entry.node_b = item_i.path_end;
    end else if (item_i.edge_from < item_i.edge_to) begin
      entry.node_a = item_i.edge_from;
      entry.node_b = item_i.edge_to;
    end else begin
      entry.node_a = item_i.edge_to;
      entry.node_b = item_i.edge_from;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= entry;
    end
  end

endmodule

// ===== rtl/spd_back.sv =====
// Back end: adjacency store with its clearing pass, edge updates, the Dijkstra
// search, path backtrack and result output. Depends on spd_pkg and spd_out_if.
module spd_back #(
  parameter int unsigned MAX_NODES = spd_pkg::MaxNodesDef,
  parameter int unsigned COST_BITS = spd_pkg::CostBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [spd_pkg::NumNodesW-1:0] num_nodes_i,
  input  logic                          cmd_valid_i,
  input  spd_pkg::spd_cmd_t             cmd_i,
  output logic                          cmd_ready_o,
  output logic                          clear_busy_o,
  spd_out_if.source                     result_o
);

  localparam int unsigned NW       = $clog2(MAX_NODES);
  localparam int unsigned AW       = 2 * NW;
  localparam int unsigned AdjDepth = 1 << AW;
  localparam int unsigned DW       = COST_BITS + NW;
  localparam int unsigned NodeW    = spd_pkg::NodeW;
  localparam int unsigned N7       = spd_pkg::NumNodesW;
  localparam logic [N7-1:0] MaxN   = N7'(MAX_NODES);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_EDGE_RD = 11'b000_0000_0100,
    S_EDGE_WR = 11'b000_0000_1000,
    S_SCAN    = 11'b000_0001_0000,
    S_RELAX   = 11'b000_0010_0000,
    S_BT_PUSH = 11'b000_0100_0000,
    S_BT_RD   = 11'b000_1000_0000,
    S_BT_LD   = 11'b001_0000_0000,
    S_EMIT_RD = 11'b010_0000_0000,
    S_EMIT_LD = 11'b100_0000_0000
  } state_e;

  // Memories
  logic [COST_BITS:0] adj_mem   [AdjDepth];
  logic [DW-1:0]      dist_mem  [MAX_NODES];
  logic [NW-1:0]      pred_mem  [MAX_NODES];
  logic [NodeW-1:0]   stack_mem [MAX_NODES];

  logic [COST_BITS:0] adj_rd_q;
  logic [DW-1:0]      dist_rd_q;
  logic [NW-1:0]      pred_rd_q;
  logic [NodeW-1:0]   stack_rd_q;

  logic               adj_we, dist_we, pred_we, stk_we;
  logic [AW-1:0]      adj_wa, adj_ra;
  logic [COST_BITS:0] adj_wd;
  logic [NW-1:0]      dist_wa, dist_ra, pred_wa, pred_ra, stk_wa, stk_ra;
  logic [DW-1:0]      dist_wd;
  logic [NW-1:0]      pred_wd;
  logic [NodeW-1:0]   stk_wd;

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [NodeW-1:0]       a_q, a_d, b_q, b_d, at_q, at_d;
  logic [COST_BITS-1:0]   cost_q, cost_d;
  logic [N7-1:0]          idx_q, idx_d, cnt_q, cnt_d;
  logic                   pv_q, pv_d, found_q, found_d;
  logic [NW-1:0]          pi_q, pi_d, cur_q, cur_d;
  logic [DW-1:0]          best_q, best_d;
  logic [MAX_NODES-1:0]   reached_q, reached_d, settled_q, settled_d, haspred_q, haspred_d;
  logic                   out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [NodeW-1:0]       out_node_q, out_node_d;

  logic [NW-1:0] idx_n, rlx_lo, rlx_hi;
  logic [DW-1:0] nd;
  logic          issue, more, hp;

  assign idx_n  = idx_q[NW-1:0];
  assign issue  = (idx_q < num_nodes_i);
  assign rlx_lo = (cur_q < idx_n) ? cur_q : idx_n;
  assign rlx_hi = (cur_q < idx_n) ? idx_n : cur_q;
  assign adj_ra = (state_q == S_RELAX) ? {rlx_lo, rlx_hi} : {a_q[NW-1:0], b_q[NW-1:0]};
  assign dist_ra = idx_n;
  assign pred_ra = at_q[NW-1:0];
  assign stk_ra  = idx_n;
  assign nd      = best_q + DW'(adj_rd_q[COST_BITS-1:0]);
  assign hp      = (N7'(at_q) < MaxN) ? haspred_q[at_q[NW-1:0]] : 1'b0;
  assign more    = hp && (N7'(cnt_q + 1'b1) < num_nodes_i);

  assign cmd_ready_o      = (state_q == S_IDLE);
  assign clear_busy_o     = (state_q == S_CLEAR);
  assign result_o.valid     = out_valid_q;
  assign result_o.path_node = out_node_q;
  assign result_o.last      = out_last_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    at_d        = at_q;
    cost_d      = cost_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pv_d        = pv_q;
    pi_d        = pi_q;
    found_d     = found_q;
    cur_d       = cur_q;
    best_d      = best_q;
    reached_d   = reached_q;
    settled_d   = settled_q;
    haspred_d   = haspred_q;
    out_valid_d = out_valid_q;
    out_node_d  = out_node_q;
    out_last_d  = out_last_q;
    adj_we  = 1'b0;
    adj_wa  = {a_q[NW-1:0], b_q[NW-1:0]};
    adj_wd  = {1'b1, cost_q};
    dist_we = 1'b0;
    dist_wa = pi_q;
    dist_wd = nd;
    pred_we = 1'b0;
    pred_wa = pi_q;
    pred_wd = cur_q;
    stk_we  = 1'b0;
    stk_wa  = cnt_q[NW-1:0];
    stk_wd  = at_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        adj_we = 1'b1;
        adj_wa = clr_q;
        adj_wd = '0;
        clr_d  = AW'(clr_q + 1'b1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          a_d    = cmd_i.node_a;
          b_d    = cmd_i.node_b;
          cost_d = COST_BITS'(cmd_i.cost);
          if (!cmd_i.is_query) begin
            state_d = S_EDGE_RD;
          end else begin
            reached_d = '0;
            settled_d = '0;
            haspred_d = '0;
            at_d      = cmd_i.node_b;
            cnt_d     = '0;
            idx_d     = '0;
            found_d   = 1'b0;
            pv_d      = 1'b0;
            if (N7'(cmd_i.node_a) < num_nodes_i) begin
              reached_d[cmd_i.node_a[NW-1:0]] = 1'b1;
              dist_we = 1'b1;
              dist_wa = cmd_i.node_a[NW-1:0];
              dist_wd = '0;
              state_d = S_SCAN;
            end else begin
              state_d = S_BT_PUSH;
            end
          end
        end
      end
      S_EDGE_RD: begin
        state_d = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        // Parallel edges keep the cheaper cost only.
        if (!adj_rd_q[COST_BITS] || (cost_q < adj_rd_q[COST_BITS-1:0])) begin
          adj_we = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (pv_q && reached_q[pi_q] && !settled_q[pi_q] &&
            (!found_q || (dist_rd_q < best_q))) begin
          found_d = 1'b1;
          best_d  = dist_rd_q;
          cur_d   = pi_q;
        end
        if (issue) begin
          pv_d  = 1'b1;
          pi_d  = idx_n;
          idx_d = N7'(idx_q + 1'b1);
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            idx_d = '0;
            if (found_q) begin
              settled_d[cur_q] = 1'b1;
              state_d = S_RELAX;
            end else begin
              state_d = S_BT_PUSH;
            end
          end
        end
      end
      S_RELAX: begin
        // best_q still holds the distance of the node just settled.
        if (pv_q && adj_rd_q[COST_BITS] && (!reached_q[pi_q] || (nd < dist_rd_q))) begin
          dist_we       = 1'b1;
          pred_we       = 1'b1;
          reached_d[pi_q] = 1'b1;
          haspred_d[pi_q] = 1'b1;
        end
        if (issue) begin
          pv_d  = 1'b1;
          pi_d  = idx_n;
          idx_d = N7'(idx_q + 1'b1);
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_BT_PUSH: begin
        stk_we = 1'b1;
        cnt_d  = N7'(cnt_q + 1'b1);
        if (more) begin
          state_d = S_BT_RD;
        end else begin
          idx_d   = cnt_q;
          state_d = S_EMIT_RD;
        end
      end
      S_BT_RD: begin
        state_d = S_BT_LD;
      end
      S_BT_LD: begin
        at_d    = NodeW'(pred_rd_q);
        state_d = S_BT_PUSH;
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_node_d  = stack_rd_q;
          out_last_d  = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = N7'(idx_q - 1'b1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      reached_q   <= '0;
      settled_q   <= '0;
      haspred_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      reached_q   <= reached_d;
      settled_q   <= settled_d;
      haspred_q   <= haspred_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    at_q       <= at_d;
    cost_q     <= cost_d;
    pi_q       <= pi_d;
    cur_q      <= cur_d;
    best_q     <= best_d;
    out_node_q <= out_node_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    adj_rd_q <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_rd_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pred_we) begin
      pred_mem[pred_wa] <= pred_wd;
    end
    pred_rd_q <= pred_mem[pred_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    stack_rd_q <= stack_mem[stk_ra];
  end

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q && !cmd_ready_o)
    else $error("result or command transfer during the clearing pass");

  a_relax_from_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELAX) |-> settled_q[cur_q] && reached_q[cur_q])
    else $error("relaxing from a node that is not settled");

  a_dist_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_we |-> (N7'(dist_wa) < num_nodes_i))
    else $error("distance written for a node outside the graph");

  a_path_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_RD) |-> (idx_q < num_nodes_i))
    else $error("path longer than the node count");

endmodule

// ===== rtl/shortest_path_dijkstra_core.sv =====
// Top level of the shortest path core: configuration register and the
// front/back split. Depends on spd_pkg, spd_stream_if, spd_front and spd_back.
//
//   Channel  Direction  Carries
//   item_i   in         opcode, edge_from, edge_to, edge_cost, path_start, path_end
//   result_o out        path_node, last (one transfer per node, start to end)
//   APB      in/out     num_nodes at byte address 0
//
// An edge item is read and rewritten in the back end; the front end queues up to two items.
// A query scans the distances and relaxes from each settled node in turn, then backtracks
// and emits the path, with at most one adjacency and one distance read per cycle.
// After reset the adjacency store is swept once over its 4^clog2(MAX_NODES) entries (4096
// by default), and no item is taken meanwhile. Results wait in an output register.
module shortest_path_dijkstra_core #(
  parameter int unsigned MAX_NODES = spd_pkg::MaxNodesDef,
  parameter int unsigned COST_BITS = spd_pkg::CostBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  spd_in_if.sink                       item_i,
  spd_out_if.source                    result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spd_pkg::ApbAddrW-1:0] paddr,
  input  logic [spd_pkg::ApbDataW-1:0] pwdata,
  output logic [spd_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  localparam int unsigned N7 = spd_pkg::NumNodesW;
  localparam logic [N7-1:0] MaxN = N7'(MAX_NODES);

  logic [N7-1:0]     num_nodes_q, num_nodes_d, wr_val;
  logic              cfg_wr;
  logic              cmd_valid, cmd_ready, clear_busy;
  spd_pkg::spd_cmd_t cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == spd_pkg::RegNumNodes);
  assign wr_val = pwdata[N7-1:0];
  assign prdata = (paddr == spd_pkg::RegNumNodes) ? spd_pkg::ApbDataW'(num_nodes_q) : '0;

  // Written values are clamped into one to MAX_NODES.
  always_comb begin
    num_nodes_d = num_nodes_q;
    if (cfg_wr) begin
      if (wr_val == '0) begin
        num_nodes_d = N7'(1);
      end else if (wr_val > MaxN) begin
        num_nodes_d = MaxN;
      end else begin
        num_nodes_d = wr_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q <= MaxN;
    end else begin
      num_nodes_q <= num_nodes_d;
    end
  end

  spd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .num_nodes_i  (num_nodes_q),
    .clear_busy_i (clear_busy),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  spd_back #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_nodes_i  (num_nodes_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_ready_o  (cmd_ready),
    .clear_busy_o (clear_busy),
    .result_o     (result_o)
  );

endmodule

// ===== bench/tb_spd_pkg.sv =====
`timescale 1ns / 100ps
// Constants shared by the shortest path testbench files.
// Stands on its own, with no other package needed.
package tb_spd_pkg;
  localparam int unsigned TbMaxNodes = 64;
  localparam int unsigned DrainCycles = 200;
endpackage

// ===== bench/tb_spd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the shortest path core: watches the item and result channels,
// runs its own Dijkstra search per query and compares every path node.
// Depends on spd_pkg, tb_spd_pkg and the channel interfaces.
module tb_spd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  spd_in_if                               item_mon,
  spd_out_if                              res_mon,
  input  logic [spd_pkg::NumNodesW-1:0]   node_count_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef struct packed {
    logic [spd_pkg::NodeW-1:0] node;
    logic                      last;
  } path_step_t;

  logic        link_ok [tb_spd_pkg::TbMaxNodes][tb_spd_pkg::TbMaxNodes];
  logic [15:0] link_cost [tb_spd_pkg::TbMaxNodes][tb_spd_pkg::TbMaxNodes];
  path_step_t  expected_path [$];

  assign pending_o = expected_path.size();

  task automatic store_link(input int a, input int b, input logic [15:0] c);
    if (a < node_count_i && b < node_count_i) begin
      if (!link_ok[a][b] || c < link_cost[a][b]) begin
        link_ok[a][b] = 1'b1; link_cost[a][b] = c;
        link_ok[b][a] = 1'b1; link_cost[b][a] = c;
      end
    end
  endtask

  task automatic predict_path(input int src, input int dst);
    longint     node_dist [tb_spd_pkg::TbMaxNodes];
    bit         seen [tb_spd_pkg::TbMaxNodes];
    bit         done [tb_spd_pkg::TbMaxNodes];
    bit         has_prev [tb_spd_pkg::TbMaxNodes];
    int         prev [tb_spd_pkg::TbMaxNodes];
    int         route [$];
    int         n, cur, at;
    bit         found;
    longint     nd;
    path_step_t step;
    n = node_count_i;
    for (int i = 0; i < tb_spd_pkg::TbMaxNodes; i++) begin
      node_dist[i] = 0; seen[i] = 0; done[i] = 0; has_prev[i] = 0; prev[i] = 0;
    end
    if (src < n) begin
      seen[src] = 1;
      for (int r = 0; r < n; r++) begin
        found = 0; cur = 0;
        for (int i = 0; i < n; i++)
          if (seen[i] && !done[i] && (!found || node_dist[i] < node_dist[cur])) begin
            cur = i; found = 1;
          end
        if (!found) break;
        done[cur] = 1;
        for (int v = 0; v < n; v++) begin
          if (!link_ok[cur][v]) continue;
          nd = node_dist[cur] + longint'(link_cost[cur][v]);
          if (!seen[v] || nd < node_dist[v]) begin
            seen[v] = 1; node_dist[v] = nd; prev[v] = cur; has_prev[v] = 1;
          end
        end
      end
    end
    at = dst;
    route.push_front(at);
    while (has_prev[at] && route.size() < n) begin
      at = prev[at];
      route.push_front(at);
    end
    foreach (route[k]) begin
      step.node = route[k][spd_pkg::NodeW-1:0];
      step.last = (k == route.size() - 1);
      expected_path.insert(expected_path.size(), step);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    path_step_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_path.delete();
      for (int i = 0; i < tb_spd_pkg::TbMaxNodes; i++)
        for (int j = 0; j < tb_spd_pkg::TbMaxNodes; j++) begin
          link_ok[i][j] = 1'b0; link_cost[i][j] = '0;
        end
    end else begin
      if (item_mon.valid && item_mon.ready) begin
        if (item_mon.opcode == spd_pkg::OpEdge)
          store_link(int'(item_mon.edge_from), int'(item_mon.edge_to), item_mon.edge_cost);
        else
          predict_path(int'(item_mon.path_start), int'(item_mon.path_end));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_path.size() == 0) begin
          $display("%0t: unexpected result node %0d last %0b", $time,
                   res_mon.path_node, res_mon.last);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_path.pop_front();
          if (want.node !== res_mon.path_node || want.last !== res_mon.last) begin
            $display("%0t: path mismatch, expected node %0d last %0b, got node %0d last %0b",
                     $time, want.node, want.last, res_mon.path_node, res_mon.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb_shortest_path_dijkstra_core.sv =====
`timescale 1ns / 100ps
// Top of the shortest path core testbench: clock, reset, APB writes, item
// stimulus with idling phases, and the verdict. Depends on tb_spd_checker.
module tb_shortest_path_dijkstra_core;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [spd_pkg::ApbAddrW-1:0]  paddr = '0;
  logic [spd_pkg::ApbDataW-1:0]  pwdata = '0;
  logic [spd_pkg::ApbDataW-1:0]  prdata;
  logic                          pready;
  logic [spd_pkg::NumNodesW-1:0] node_count = 7'd64;
  int                            fail_count, pending;
  int                            send_idle_pct = 0, recv_stall_pct = 0;
  bit                            recv_hold = 1'b0;
  int                            quiet_cycles = 0;

  spd_in_if  item_ch();
  spd_out_if result_ch();

  always #5 clk_i = ~clk_i;

  shortest_path_dijkstra_core u_top (
    .clk_i, .rst_ni, .item_i(item_ch.sink), .result_o(result_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tb_spd_checker u_checker (
    .clk_i, .rst_ni, .item_mon(item_ch), .res_mon(result_ch),
    .node_count_i(node_count), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    item_ch.valid = 1'b0; item_ch.opcode = spd_pkg::OpEdge; item_ch.edge_from = '0;
    item_ch.edge_to = '0; item_ch.edge_cost = '0; item_ch.path_start = '0;
    item_ch.path_end = '0; result_ch.ready = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i)
    result_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles without any transfer; queries can be long.
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 100000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic apb_write(input logic [6:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= spd_pkg::RegNumNodes;
    pwdata <= spd_pkg::ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    // Mirror the clamping the register applies.
    node_count <= (value == 0) ? 7'd1 : (value > 64) ? 7'd64 : value;
    @(posedge clk_i);
  endtask

  // Item stays offered until transferred; idle gaps come before the offer.
  // Valid is dropped only in a gap or by stop_items, so a following item can
  // be offered in the very cycle after a transfer.
  task automatic send_item(input logic op, input int a, input int b, input int c,
                           input int s, input int e);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid <= 1'b1; item_ch.opcode <= op;
    item_ch.edge_from <= spd_pkg::NodeW'(a); item_ch.edge_to <= spd_pkg::NodeW'(b);
    item_ch.edge_cost <= spd_pkg::CostInW'(c);
    item_ch.path_start <= spd_pkg::NodeW'(s); item_ch.path_end <= spd_pkg::NodeW'(e);
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  task automatic stop_items();
    item_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tb_spd_pkg::DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_item(input int span);
    int a, b;
    a = $urandom_range(span - 1); b = $urandom_range(span - 1);
    if ($urandom_range(99) < 8) a = $urandom_range(63);
    if ($urandom_range(99) < 75)
      send_item(spd_pkg::OpEdge, a, b, ($urandom_range(3) == 0) ? $urandom_range(65535)
                : $urandom_range(40), 0, 0);
    else
      send_item(spd_pkg::OpQuery, 0, 0, 0, a, b);
  endtask

  initial begin
    int span;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();
    // Directed: chain, parallel edges, self loop, extremes, odd queries.
    send_item(spd_pkg::OpEdge, 0, 1, 5, 0, 0);
    send_item(spd_pkg::OpEdge, 1, 2, 5, 0, 0);
    send_item(spd_pkg::OpEdge, 0, 2, 10, 0, 0);
    send_item(spd_pkg::OpEdge, 2, 0, 12, 0, 0);
    send_item(spd_pkg::OpEdge, 3, 3, 0, 0, 0);
    send_item(spd_pkg::OpEdge, 63, 62, 65535, 0, 0);
    send_item(spd_pkg::OpEdge, 62, 2, 65535, 0, 0);
    send_item(spd_pkg::OpEdge, 4, 5, 0, 0, 0);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 0, 2);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 0, 63);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 63, 0);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 7, 7);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 0, 4);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 3, 3);
    stop_items();
    wait_drained();
    apb_write(7'd0);
    send_item(spd_pkg::OpEdge, 0, 1, 3, 0, 0);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 0, 0);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 1, 0);
    stop_items();
    wait_drained();
    apb_write(7'd127);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 63, 1);
    stop_items();
    wait_drained();
    apb_write(7'd4);
    send_item(spd_pkg::OpEdge, 1, 5, 1, 0, 0);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 0, 5);
    send_item(spd_pkg::OpQuery, 0, 0, 0, 6, 2);
    stop_items();
    wait_drained();
    // Random phases, each with a node count and one of four idling mixes in turn.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      apb_write((ph == 7) ? 7'd64 : (ph == 0) ? 7'd1 : 7'($urandom_range(2, 24)));
      span = (ph == 7) ? 64 : int'(node_count);
      if (ph == 2) begin
        fork
          begin
            recv_hold = 1'b1;
            repeat (3000) @(posedge clk_i);
            recv_hold = 1'b0;
          end
          begin
            for (int k = 0; k < 60; k++) random_item(span);
            stop_items();
          end
        join
      end else begin
        for (int k = 0; k < 60; k++) random_item(span);
        stop_items();
      end
      wait_drained();
    end
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
